// ----- src/vdt_pkg.sv -----
// Package for the voxel distance transform: sequencer state type, pass codes
// and the saturated distance constant. No dependencies.
package vdt_pkg;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PASS,
        ST_DRAIN,
        ST_READ
    } t_state;

    typedef enum logic [1:0] {
        PASS_INNER,
        PASS_MIDDLE,
        PASS_OUTER
    } t_pass;

    localparam int DIST_W = 14;
    localparam logic [DIST_W-1:0] DIST_SAT = 14'h3FFF;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] REG_SIZE_OUTER  = 2'd0;
    localparam logic [1:0] REG_SIZE_MIDDLE = 2'd1;
    localparam logic [1:0] REG_SIZE_INNER  = 2'd2;

endpackage

// ----- src/voxel_distance_transform.sv -----
// Voxel distance transform top level: grid load, three separable passes over
// two on-chip buffers, and raster readout. Depends on vdt_pkg.
//
// Channel   Signals                                  Transaction
// command   i_start, i_operation, i_occupied, o_busy  start && !busy
// result    o_valid, o_squared_distance, o_no_seed,   o_valid, one cycle
//           o_last
// config    i_cfg_we, i_cfg_index, i_cfg_data         i_cfg_we
//
// Loads and reads may follow every cycle while o_busy is low. After the
// last voxel the block is busy while it runs the three passes; each voxel's
// line is scanned one candidate a cycle through the buffer read port. A read
// result appears in the cycle after its transaction. Reset and any size
// write return the block to loading; the receiver cannot stall.
module voxel_distance_transform #(
    parameter int MAX_EDGE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_operation,
    input  logic        i_occupied,
    output logic        o_busy,
    output logic        o_valid,
    output logic [13:0] o_squared_distance,
    output logic        o_no_seed,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    import vdt_pkg::*;

    localparam int CW    = $clog2(MAX_EDGE);
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int SQW   = 2 * CW;
    localparam int SW    = ((SQW > DIST_W) ? SQW : DIST_W) + 1;

    logic [DIST_W-1:0] mem_a [DEPTH];
    logic [DIST_W-1:0] mem_b [DEPTH];

    logic [6:0] r_size_o, r_size_m, r_size_i;
    t_state r_state, n_state;
    t_pass  r_pass;
    logic   r_seed;

    logic [CW-1:0] r_pi, r_pj, r_pk;
    logic [CW-1:0] r_ci, r_cj, r_ck, r_t;

    logic              r_s1_v, r_s1_first, r_s1_end;
    logic [SQW-1:0]    r_s1_sq;
    logic [AW-1:0]     r_s1_dst;
    t_pass             r_s1_pass;
    logic [DIST_W-1:0] r_best;
    logic [DIST_W-1:0] r_rd_a, r_rd_b;

    logic r_ov, r_olast, r_onos;

    logic [CW-1:0] lim_o, lim_m, lim_i, lim_ax, ctr_ax, line_off;
    logic          pos_last, ctr_last, t_end, issue_last;
    logic          cmd, ld_acc, rd_acc, restart;
    logic [AW-1:0] src_addr;

    logic              we_a, we_b;
    logic [AW-1:0]     wa_a, ra_a, ra_b;
    logic [DIST_W-1:0] wd_a, src_val, cand, n_best;
    logic [SW-1:0]     sum;

    function automatic logic [CW-1:0] lim_of(input logic [6:0] s);
        logic [8:0] w;
        w = {2'b00, s};
        if (s == 7'd0) begin
            lim_of = '0;
        end else if (w > 9'(MAX_EDGE)) begin
            lim_of = CW'(MAX_EDGE - 1);
        end else begin
            lim_of = CW'(w - 9'd1);
        end
    endfunction

    assign lim_o = lim_of(r_size_o);
    assign lim_m = lim_of(r_size_m);
    assign lim_i = lim_of(r_size_i);

    assign cmd      = i_start && !o_busy;
    assign ld_acc   = cmd && (i_operation == OP_LOAD) && (r_state == ST_LOAD);
    assign rd_acc   = cmd && (i_operation == OP_READ) && (r_state == ST_READ);
    assign restart  = i_cfg_we && (i_cfg_index == REG_SIZE_OUTER
                      || i_cfg_index == REG_SIZE_MIDDLE || i_cfg_index == REG_SIZE_INNER);
    assign pos_last = (r_pi == lim_o) && (r_pj == lim_m) && (r_pk == lim_i);
    assign ctr_last = (r_ci == lim_o) && (r_cj == lim_m) && (r_ck == lim_i);

    always_comb begin
        case (r_pass)
            PASS_INNER: begin
                lim_ax = lim_i; ctr_ax = r_ck; src_addr = {r_ci, r_cj, r_t};
            end
            PASS_MIDDLE: begin
                lim_ax = lim_m; ctr_ax = r_cj; src_addr = {r_ci, r_t, r_ck};
            end
            default: begin
                lim_ax = lim_o; ctr_ax = r_ci; src_addr = {r_t, r_cj, r_ck};
            end
        endcase
    end

    assign t_end      = (r_t == lim_ax);
    assign issue_last = (r_state == ST_PASS) && t_end && ctr_last;
    assign line_off   = (r_t > ctr_ax) ? (r_t - ctr_ax) : (ctr_ax - r_t);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:  if (ld_acc && pos_last) n_state = ST_PASS;
            ST_PASS:  if (issue_last) n_state = ST_DRAIN;
            ST_DRAIN: n_state = (r_pass == PASS_OUTER) ? ST_READ : ST_PASS;
            ST_READ:  if (rd_acc && pos_last) n_state = ST_LOAD;
            default:  n_state = ST_LOAD;
        endcase
        if (restart) n_state = ST_LOAD;
    end

    always_comb begin
        o_busy  = (r_state == ST_PASS) || (r_state == ST_DRAIN);
        src_val = (r_s1_pass == PASS_MIDDLE) ? r_rd_b : r_rd_a;
        sum     = SW'(src_val) + SW'(r_s1_sq);
        if (r_s1_pass == PASS_INNER) begin
            if (src_val != '0) begin
                cand = (SW'(r_s1_sq) > SW'(DIST_SAT)) ? DIST_SAT : DIST_W'(r_s1_sq);
            end else begin
                cand = DIST_SAT;
            end
        end else begin
            cand = (sum > SW'(DIST_SAT)) ? DIST_SAT : DIST_W'(sum);
        end
        n_best = (r_s1_first || cand < r_best) ? cand : r_best;
        we_a = ld_acc || (r_s1_v && r_s1_end && r_s1_pass == PASS_MIDDLE);
        we_b = r_s1_v && r_s1_end && r_s1_pass != PASS_MIDDLE;
        wa_a = ld_acc ? {r_pi, r_pj, r_pk} : r_s1_dst;
        wd_a = ld_acc ? {{(DIST_W-1){1'b0}}, i_occupied} : n_best;
        ra_a = src_addr;
        ra_b = (r_state == ST_READ) ? {r_pi, r_pj, r_pk} : src_addr;
    end

    always_ff @(posedge i_clk) begin
        if (we_a) mem_a[wa_a] <= wd_a;
        r_rd_a <= mem_a[ra_a];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) mem_b[r_s1_dst] <= n_best;
        r_rd_b <= mem_b[ra_b];
    end

    always_ff @(posedge i_clk) begin
        r_s1_sq    <= SQW'(line_off) * SQW'(line_off);
        r_s1_dst   <= {r_ci, r_cj, r_ck};
        r_s1_pass  <= r_pass;
        r_s1_first <= (r_t == '0);
        r_s1_end   <= t_end;
        if (r_s1_v) r_best <= n_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_o <= 7'd64;
            r_size_m <= 7'd64;
            r_size_i <= 7'd64;
            r_state  <= ST_LOAD;
            r_pass   <= PASS_INNER;
            r_seed   <= 1'b0;
            {r_pi, r_pj, r_pk} <= '0;
            {r_ci, r_cj, r_ck} <= '0;
            r_t      <= '0;
            r_s1_v   <= 1'b0;
            r_ov     <= 1'b0;
            r_olast  <= 1'b0;
            r_onos   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1_v  <= (r_state == ST_PASS);
            r_ov    <= rd_acc;
            if (rd_acc) begin
                r_olast <= pos_last;
                r_onos  <= !r_seed;
            end
            if (restart) begin
                {r_pi, r_pj, r_pk} <= '0;
            end else if (ld_acc || rd_acc) begin
                if (pos_last) begin
                    {r_pi, r_pj, r_pk} <= '0;
                end else if (r_pk != lim_i) begin
                    r_pk <= r_pk + 1'b1;
                end else if (r_pj != lim_m) begin
                    r_pk <= '0;
                    r_pj <= r_pj + 1'b1;
                end else begin
                    r_pk <= '0;
                    r_pj <= '0;
                    r_pi <= r_pi + 1'b1;
                end
            end
            if (restart || (rd_acc && pos_last)) begin
                r_seed <= 1'b0;
            end else if (ld_acc && i_occupied) begin
                r_seed <= 1'b1;
            end
            if (r_state == ST_LOAD) begin
                r_pass <= PASS_INNER;
                r_t    <= '0;
                {r_ci, r_cj, r_ck} <= '0;
            end else if (r_state == ST_DRAIN) begin
                r_pass <= (r_pass == PASS_INNER) ? PASS_MIDDLE : PASS_OUTER;
            end else if (r_state == ST_PASS) begin
                if (!t_end) begin
                    r_t <= r_t + 1'b1;
                end else begin
                    r_t <= '0;
                    if (ctr_last) begin
                        {r_ci, r_cj, r_ck} <= '0;
                    end else if (r_ck != lim_i) begin
                        r_ck <= r_ck + 1'b1;
                    end else if (r_cj != lim_m) begin
                        r_ck <= '0;
                        r_cj <= r_cj + 1'b1;
                    end else begin
                        r_ck <= '0;
                        r_cj <= '0;
                        r_ci <= r_ci + 1'b1;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SIZE_OUTER:  r_size_o <= i_cfg_data;
                    REG_SIZE_MIDDLE: r_size_m <= i_cfg_data;
                    REG_SIZE_INNER:  r_size_i <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_valid            = r_ov;
    assign o_squared_distance = r_rd_b;
    assign o_no_seed          = r_onos;
    assign o_last             = r_olast;

endmodule

// ----- sim/voxel_distance_transform_tb.sv -----
// Self-checking testbench for voxel_distance_transform: loads random 3D grids,
// predicts each squared distance in a local model and checks every readout.
// Depends on vdt_pkg and the voxel_distance_transform RTL.
module voxel_distance_transform_tb;
    import vdt_pkg::*;

    localparam int EDGE = 64;
    localparam int CELLS = EDGE * EDGE * EDGE;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              no_seed;
        logic              last;
    } t_voxel_readout;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_operation = OP_LOAD;
    logic        i_occupied = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_SIZE_OUTER;
    logic [6:0]  i_cfg_data = 7'd0;
    logic        o_busy;
    logic        o_valid;
    logic [13:0] o_squared_distance;
    logic        o_no_seed;
    logic        o_last;

    voxel_distance_transform #(.MAX_EDGE(EDGE)) uut (.*);

    always #5 i_clk = ~i_clk;

    // Local copy of the grid state and sizes.
    logic [DIST_W-1:0] occ_grid [CELLS];
    logic [DIST_W-1:0] line_tmp [CELLS];
    logic [DIST_W-1:0] dist_grid [CELLS];
    int unsigned       size_reg [3];
    int unsigned       load_pos, read_pos;
    bit                reading_out, seed_seen;

    t_voxel_readout expected_readouts [$];
    int errors = 0;
    int items_sent = 0;
    int readouts_checked = 0;
    int grids_done = 0;
    int gap_pct = 0;

    function automatic int unsigned eff_size(int unsigned s);
        if (s == 0) return 1;
        if (s > EDGE) return EDGE;
        return s;
    endfunction

    function automatic int unsigned sq_dist(int unsigned a, int unsigned b);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    function automatic int unsigned clamp_sum(int unsigned a, int unsigned b);
        return (a + b > DIST_SAT) ? DIST_SAT : a + b;
    endfunction

    function automatic void restart_grid();
        load_pos = 0;
        read_pos = 0;
        reading_out = 0;
        seed_seen = 0;
    endfunction

    function automatic void compute_distances();
        int unsigned no, nm, ni, best, v;
        no = eff_size(size_reg[REG_SIZE_OUTER]);
        nm = eff_size(size_reg[REG_SIZE_MIDDLE]);
        ni = eff_size(size_reg[REG_SIZE_INNER]);
        for (int i = 0; i < no; i++)
            for (int j = 0; j < nm; j++)
                for (int k = 0; k < ni; k++) begin
                    best = DIST_SAT;
                    for (int t = 0; t < ni; t++)
                        if (occ_grid[(i * nm + j) * ni + t] != 0) begin
                            v = clamp_sum(sq_dist(t, k), 0);
                            if (v < best) best = v;
                        end
                    dist_grid[(i * nm + j) * ni + k] = DIST_W'(best);
                end
        for (int i = 0; i < no; i++)
            for (int j = 0; j < nm; j++)
                for (int k = 0; k < ni; k++) begin
                    best = DIST_SAT;
                    for (int t = 0; t < nm; t++) begin
                        v = clamp_sum(dist_grid[(i * nm + t) * ni + k], sq_dist(t, j));
                        if (v < best) best = v;
                    end
                    line_tmp[(i * nm + j) * ni + k] = DIST_W'(best);
                end
        for (int i = 0; i < no; i++)
            for (int j = 0; j < nm; j++)
                for (int k = 0; k < ni; k++) begin
                    best = DIST_SAT;
                    for (int t = 0; t < no; t++) begin
                        v = clamp_sum(line_tmp[(t * nm + j) * ni + k], sq_dist(t, i));
                        if (v < best) best = v;
                    end
                    dist_grid[(i * nm + j) * ni + k] = DIST_W'(best);
                end
    endfunction

    function automatic void predict_transaction(logic op, logic occ);
        int unsigned total;
        t_voxel_readout r;
        total = eff_size(size_reg[REG_SIZE_OUTER]) * eff_size(size_reg[REG_SIZE_MIDDLE])
              * eff_size(size_reg[REG_SIZE_INNER]);
        if (op == OP_LOAD) begin
            if (reading_out || load_pos >= total) return;
            occ_grid[load_pos] = {{(DIST_W-1){1'b0}}, occ};
            if (occ) seed_seen = 1;
            load_pos++;
            if (load_pos >= total) begin
                compute_distances();
                read_pos = 0;
                reading_out = 1;
            end
        end else begin
            if (!reading_out || read_pos >= total) return;
            r.distance = dist_grid[read_pos];
            r.no_seed = !seed_seen;
            read_pos++;
            r.last = (read_pos >= total);
            expected_readouts = {expected_readouts, r};
            if (r.last) restart_grid();
        end
    endfunction

    // Checks every readout against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_readouts.size() == 0) begin
                $error("Unexpected readout: distance %0d", o_squared_distance);
                errors++;
            end else begin
                t_voxel_readout e;
                e = expected_readouts.pop_front();
                readouts_checked++;
                if (o_squared_distance !== e.distance) begin
                    $error("squared_distance: expected %0d, got %0d", e.distance,
                           o_squared_distance);
                    errors++;
                end
                if (o_no_seed !== e.no_seed) begin
                    $error("no_seed: expected %0d, got %0d", e.no_seed, o_no_seed);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, o_last);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(logic op, logic occ, bit counted);
        logic busy_seen;
        i_start <= 1'b1;
        i_operation <= op;
        i_occupied <= occ;
        do begin
            @(negedge i_clk);
            busy_seen = o_busy;
            @(posedge i_clk);
        end while (busy_seen);
        predict_transaction(op, occ);
        if (counted) items_sent++;
        if ($urandom_range(99) < gap_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_readouts.size() != 0 || o_busy) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_size(logic [1:0] idx, logic [6:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        size_reg[idx] = value;
        restart_grid();
    endtask

    task automatic set_sizes(logic [6:0] so, logic [6:0] sm, logic [6:0] si);
        wait_drained();
        write_size(REG_SIZE_OUTER, so);
        write_size(REG_SIZE_MIDDLE, sm);
        write_size(REG_SIZE_INNER, si);
        i_cfg_we <= 1'b0;
    endtask

    // Loads one full grid and reads it back, with occasional ignored items.
    task automatic run_grid(logic [6:0] so, logic [6:0] sm, logic [6:0] si, int density);
        int unsigned total;
        set_sizes(so, sm, si);
        total = eff_size(so) * eff_size(sm) * eff_size(si);
        for (int n = 0; n < total; n++) begin
            if ($urandom_range(99) < 5) send_item(OP_READ, 1'($urandom_range(1)), 0);
            send_item(OP_LOAD, $urandom_range(99) < density, 1);
        end
        for (int n = 0; n < total; n++) begin
            if (n > 0 && $urandom_range(99) < 5) send_item(OP_LOAD, 1'($urandom_range(1)), 0);
            send_item(OP_READ, 1'($urandom_range(1)), 1);
        end
        grids_done++;
    endtask

    task automatic test_directed_extremes();
        run_grid(7'd1, 7'd1, 7'd1, 100);
        run_grid(7'd1, 7'd1, 7'd1, 0);
        run_grid(7'd0, 7'd0, 7'd0, 100);
        run_grid(7'd2, 7'd2, 7'd2, 30);
    endtask

    task automatic test_restart_on_write();
        set_sizes(7'd2, 7'd2, 7'd2);
        repeat (3) send_item(OP_LOAD, 1'b1, 1);
        set_sizes(7'd1, 7'd2, 7'd3);
        repeat (6) send_item(OP_LOAD, 1'b0, 1);
        repeat (6) send_item(OP_READ, 1'b0, 1);
        grids_done++;
    endtask

    task automatic test_long_axes();
        run_grid(7'd127, 7'd1, 7'd1, 3);
        run_grid(7'd1, 7'd64, 7'd1, 3);
        run_grid(7'd1, 7'd1, 7'd64, 3);
    endtask

    task automatic test_random_grids();
        int pct [4] = '{0, 47, 47, 11};
        int dens;
        int base;
        base = items_sent;
        for (int ph = 0; ph < 4; ph++) begin
            gap_pct = pct[ph];
            while (items_sent < base + (1350 - base) * (ph + 1) / 4) begin
                case ($urandom_range(4))
                    0: dens = 0;
                    1: dens = 100;
                    2: dens = 5;
                    default: dens = $urandom_range(10, 60);
                endcase
                run_grid(7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)),
                         7'($urandom_range(1, 5)), dens);
            end
            wait_drained();
        end
    endtask

    initial begin
        size_reg = '{64, 64, 64};
        restart_grid();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_restart_on_write();
        test_long_axes();
        test_random_grids();
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d counted transactions over %0d grids, %0d readouts checked,",
                 items_sent, grids_done, readouts_checked);
        $display("including empty grids, out-of-range sizes and 64-voxel axes.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
